/* hdl/rost_pkg.sv */
// Package with shared types and constants of the ray versus oriented box test unit.
package rost_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_BOX_CENTER   = 3'd0,
      REG_AXIS_U       = 3'd1,
      REG_AXIS_V       = 3'd2,
      REG_AXIS_W       = 3'd3,
      REG_HALF_EXTENTS = 3'd4
   } csr_index_type;

   localparam int unsigned CSR_W = 48;
   localparam int unsigned FLD_W = 16;
   localparam int unsigned NUM_STAGES = 6;

   localparam logic [CSR_W-1:0] AXIS_U_RESET = 48'h0000_0000_4000;
   localparam logic [CSR_W-1:0] AXIS_V_RESET = 48'h0000_4000_0000;
   localparam logic [CSR_W-1:0] AXIS_W_RESET = 48'h4000_0000_0000;

   typedef logic [CSR_W-1:0] csr_word_type;

endpackage

/* hdl/ray_obb_separating_axis_test_unit.sv */
// Top level of the pipelined ray versus oriented box separating-axis test.
//
// The box (center, three axes, three half-extents) is held in five 48-bit
// registers written through the csr_ port; writes take effect at once. The
// user must write only while no item is in flight; the unit does not enforce it.
// Each ray arrives as one item on the req_ channel (origin in signed Q7.8,
// direction in signed Q1.14) and leaves on rsp_ carrying a single hit bit.
//
// The datapath is a six-stage pipeline: offset, component products, dot and
// cross sums, slab test with the projected cross products, extent products,
// and the final compares. rsp_valid and rsp_hit come from the last stage's
// register, and one ray is accepted every cycle while req_ready is high.
// Each stage holds its item until the next stage frees up, so a stalled
// receiver fills the pipeline bubbles first; req_ready drops only when all
// six stages hold an item and the output is not taken.
// Reset empties the pipeline and restores the unit box axes with zero
// center and zero half-extents.
module ray_obb_separating_axis_test_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [15:0]     req_origin_x,
   input  logic signed [15:0]     req_origin_y,
   input  logic signed [15:0]     req_origin_z,
   input  logic signed [15:0]     req_dir_x,
   input  logic signed [15:0]     req_dir_y,
   input  logic signed [15:0]     req_dir_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_hit,
   input  logic                   csr_we,
   input  logic [2:0]             csr_addr,
   input  rost_pkg::csr_word_type csr_wdata
);
   import rost_pkg::*;

   // Configuration registers.
   csr_word_type center_ff, axis_u_ff, axis_v_ff, axis_w_ff, ext_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         axis_u_ff <= AXIS_U_RESET;
         axis_v_ff <= AXIS_V_RESET;
         axis_w_ff <= AXIS_W_RESET;
         ext_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_BOX_CENTER:   center_ff <= csr_wdata;
            REG_AXIS_U:       axis_u_ff <= csr_wdata;
            REG_AXIS_V:       axis_v_ff <= csr_wdata;
            REG_AXIS_W:       axis_w_ff <= csr_wdata;
            REG_HALF_EXTENTS: ext_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic signed [15:0] ax_c  [3][3];   // [axis][component]
   logic signed [15:0] ctr_c [3];
   logic        [15:0] ext_c [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ax_c[0][j] = axis_u_ff[j*FLD_W +: FLD_W];
         ax_c[1][j] = axis_v_ff[j*FLD_W +: FLD_W];
         ax_c[2][j] = axis_w_ff[j*FLD_W +: FLD_W];
         ctr_c[j]   = center_ff[j*FLD_W +: FLD_W];
         ext_c[j]   = ext_ff[j*FLD_W +: FLD_W];
      end
   end

   // Valid bits and per-stage advance.
   logic [NUM_STAGES-1:0] vld_ff, vld_in, adv;

   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // Stage 0: offset from the box center and the direction.
   logic signed [16:0] d0_ff [3], d0_in [3];
   logic signed [15:0] w0_ff [3], w0_in [3];

   always_comb begin
      w0_in[0] = req_dir_x;
      w0_in[1] = req_dir_y;
      w0_in[2] = req_dir_z;
      d0_in[0] = 17'(req_origin_x) - 17'(ctr_c[0]);
      d0_in[1] = 17'(req_origin_y) - 17'(ctr_c[1]);
      d0_in[2] = 17'(req_origin_z) - 17'(ctr_c[2]);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         d0_ff <= d0_in;
         w0_ff <= w0_in;
      end
   end

   // Stage 1: all component products.
   logic signed [31:0] pw1_ff [3][3], pw1_in [3][3];
   logic signed [32:0] pd1_ff [3][3], pd1_in [3][3];
   logic signed [31:0] pc1_ff [6], pc1_in [6];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pw1_in[i][j] = 32'(w0_ff[j]) * 32'(ax_c[i][j]);
            pd1_in[i][j] = 33'(d0_ff[j]) * 33'(ax_c[i][j]);
         end
      end
      pc1_in[0] = 32'(w0_ff[1]) * 32'(d0_ff[2]);
      pc1_in[1] = 32'(w0_ff[2]) * 32'(d0_ff[1]);
      pc1_in[2] = 32'(w0_ff[2]) * 32'(d0_ff[0]);
      pc1_in[3] = 32'(w0_ff[0]) * 32'(d0_ff[2]);
      pc1_in[4] = 32'(w0_ff[0]) * 32'(d0_ff[1]);
      pc1_in[5] = 32'(w0_ff[1]) * 32'(d0_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         pw1_ff <= pw1_in;
         pd1_ff <= pd1_in;
         pc1_ff <= pc1_in;
      end
   end

   // Stage 2: direction and offset projections, and the cross product.
   logic signed [32:0] wdu2_ff [3], wdu2_in [3];
   logic signed [33:0] ddu2_ff [3], ddu2_in [3];
   logic signed [32:0] cr2_ff  [3], cr2_in  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wdu2_in[i] = 33'(pw1_ff[i][0]) + 33'(pw1_ff[i][1]) + 33'(pw1_ff[i][2]);
         ddu2_in[i] = 34'(pd1_ff[i][0]) + 34'(pd1_ff[i][1]) + 34'(pd1_ff[i][2]);
         cr2_in[i]  = 33'(pc1_ff[2*i]) - 33'(pc1_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         wdu2_ff <= wdu2_in;
         ddu2_ff <= ddu2_in;
         cr2_ff  <= cr2_in;
      end
   end

   // Stage 3: slab tests, direction magnitudes, cross product on each axis.
   logic               rej3_ff, rej3_in;
   logic        [31:0] awdu3_ff [3], awdu3_in [3];
   logic signed [47:0] pcr3_ff [3][3], pcr3_in [3][3];
   logic        [32:0] addu3;
   logic               same3;

   always_comb begin
      rej3_in = 1'b0;
      addu3   = '0;
      same3   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         awdu3_in[i] = 32'(wdu2_ff[i][32] ? -wdu2_ff[i] : wdu2_ff[i]);
         addu3 = 33'(ddu2_ff[i][33] ? -ddu2_ff[i] : ddu2_ff[i]);
         // A zero on either side counts as pointing the same way.
         same3 = (ddu2_ff[i] == '0) || (wdu2_ff[i] == '0) ||
                 (ddu2_ff[i][33] == wdu2_ff[i][32]);
         if (same3 && (addu3 > {3'b000, ext_c[i], 14'b0})) begin
            rej3_in = 1'b1;
         end
         for (int j = 0; j < 3; j++) begin
            pcr3_in[i][j] = 48'(cr2_ff[j]) * 48'(ax_c[i][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         rej3_ff  <= rej3_in;
         awdu3_ff <= awdu3_in;
         pcr3_ff  <= pcr3_in;
      end
   end

   // Stage 4: cross projections summed, extent-weighted direction products.
   logic               rej4_ff;
   logic signed [49:0] dcr4_ff [3], dcr4_in [3];
   logic        [47:0] pe4_ff [6], pe4_in [6];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dcr4_in[i] = 50'(pcr3_ff[i][0]) + 50'(pcr3_ff[i][1]) + 50'(pcr3_ff[i][2]);
      end
      pe4_in[0] = 48'(ext_c[1]) * 48'(awdu3_ff[2]);
      pe4_in[1] = 48'(ext_c[2]) * 48'(awdu3_ff[1]);
      pe4_in[2] = 48'(ext_c[0]) * 48'(awdu3_ff[2]);
      pe4_in[3] = 48'(ext_c[2]) * 48'(awdu3_ff[0]);
      pe4_in[4] = 48'(ext_c[0]) * 48'(awdu3_ff[1]);
      pe4_in[5] = 48'(ext_c[1]) * 48'(awdu3_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         rej4_ff <= rej3_ff;
         dcr4_ff <= dcr4_in;
         pe4_ff  <= pe4_in;
      end
   end

   // Stage 5: cross-axis compares and the result register.
   logic        hit_ff, hit_in;
   logic [49:0] adcr5;
   logic [49:0] lim5;

   always_comb begin
      hit_in = !rej4_ff;
      adcr5  = '0;
      lim5   = '0;
      for (int i = 0; i < 3; i++) begin
         adcr5 = 50'(dcr4_ff[i][49] ? -dcr4_ff[i] : dcr4_ff[i]);
         lim5  = 50'(pe4_ff[2*i]) + 50'(pe4_ff[2*i+1]);
         if (adcr5 > lim5) begin
            hit_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_hit = hit_ff;

endmodule

/* hdl/rost_checker.sv */
// Port-level checker for the ray versus oriented box test unit, with its bind.
module rost_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit
);

   // The pipeline can only refuse an item when the output holds one that is not taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without an output stall");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hit)))
      else $error("result item changed or dropped while stalled");

   // Nothing can leave the last stage during the first cycles after reset.
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid ##1 !rsp_valid)
      else $error("result item appeared too early after reset");

endmodule

bind ray_obb_separating_axis_test_unit rost_checker u_rost_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_hit   (rsp_hit)
);
